>>> sv/url_percent_decoder_assert.svh
// assertion macros for the url percent decoder checker
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// clocked assertion, off while reset is held
`define URL_PCT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define URL_PCT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/url_pct_pkg.sv
// types, constants and helper functions for the url percent decoder
package url_pct_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned NumW       = $clog2(MaxResults + 1);

  localparam logic [ByteW-1:0] ChPercent = 8'h25;
  localparam logic [ByteW-1:0] ChPlus    = 8'h2b;
  localparam logic [ByteW-1:0] ChSpace   = 8'h20;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_PCT  = 2'd1,
    MODE_HELD = 2'd2
  } mode_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } result_t;

  // results of one decoded request, oldest in entry 0
  typedef struct packed {
    logic [NumW-1:0]                num;
    result_t [MaxResults-1:0]       res;
  } dec_t;

  function automatic logic hex_ok(input logic [ByteW-1:0] c);
    hex_ok = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  // only meaningful for hex digits; letters of both cases share the low nibble
  function automatic logic [3:0] hex_val(input logic [ByteW-1:0] c);
    if (c <= 8'h39) begin
      hex_val = c[3:0];
    end else begin
      hex_val = c[3:0] + 4'd9;
    end
  endfunction

  function automatic logic [ByteW-1:0] plain(input logic [ByteW-1:0] c);
    plain = (c == ChPlus) ? ChSpace : c;
  endfunction

endpackage

>>> sv/url_pct_if.sv
// request and result channel interfaces of the url percent decoder
interface url_pct_in_if;
  logic                          valid;
  logic                          ready;
  logic [url_pct_pkg::ByteW-1:0] in_byte;
  logic                          in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface url_pct_out_if;
  logic                          valid;
  logic                          ready;
  logic [url_pct_pkg::ByteW-1:0] out_byte;
  logic                          out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> sv/url_pct_core.sv
// escape tracking and combinational decode of one input byte
module url_pct_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  url_pct_in_if.sink          req_i,
  output url_pct_pkg::dec_t   dec_o
);

  url_pct_pkg::mode_e                mode_q, mode_d;
  logic [url_pct_pkg::ByteW-1:0]     held_q, held_d;
  logic                              accept;
  logic [url_pct_pkg::ByteW-1:0]     c;
  logic                              last;

  assign req_i.ready = take_i;
  assign accept      = req_i.valid && take_i;
  assign c           = req_i.in_byte;
  assign last        = req_i.in_last;

  always_comb begin
    mode_d = mode_q;
    held_d = held_q;
    dec_o  = '0;
    case (mode_q)
      url_pct_pkg::MODE_PCT: begin
        if (last) begin
          dec_o.num         = url_pct_pkg::NumW'(2);
          dec_o.res[0].data = url_pct_pkg::ChPercent;
          dec_o.res[1].data = url_pct_pkg::plain(c);
          dec_o.res[1].last = 1'b1;
          mode_d            = url_pct_pkg::MODE_IDLE;
          held_d            = '0;
        end else begin
          held_d = c;
          mode_d = url_pct_pkg::MODE_HELD;
        end
      end
      url_pct_pkg::MODE_HELD: begin
        if (url_pct_pkg::hex_ok(held_q) && url_pct_pkg::hex_ok(c)) begin
          dec_o.num         = url_pct_pkg::NumW'(1);
          dec_o.res[0].data = {url_pct_pkg::hex_val(held_q), url_pct_pkg::hex_val(c)};
          dec_o.res[0].last = last;
        end else begin
          // not an escape after all: pass all three bytes raw
          dec_o.num         = url_pct_pkg::NumW'(3);
          dec_o.res[0].data = url_pct_pkg::ChPercent;
          dec_o.res[1].data = held_q;
          dec_o.res[2].data = c;
          dec_o.res[2].last = last;
        end
        mode_d = url_pct_pkg::MODE_IDLE;
        held_d = '0;
      end
      default: begin
        if (c == url_pct_pkg::ChPercent && !last) begin
          mode_d = url_pct_pkg::MODE_PCT;
        end else begin
          dec_o.num         = url_pct_pkg::NumW'(1);
          dec_o.res[0].data = url_pct_pkg::plain(c);
          dec_o.res[0].last = last;
          mode_d            = url_pct_pkg::MODE_IDLE;
          if (last) begin
            held_d = '0;
          end
        end
      end
    endcase
    if (!accept) begin
      mode_d    = mode_q;
      held_d    = held_q;
      dec_o.num = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= url_pct_pkg::MODE_IDLE;
      held_q <= '0;
    end else begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

endmodule

>>> sv/url_pct_out_queue.sv
// result queue: takes up to three results at once, hands out one per cycle while the receiver is ready
module url_pct_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  url_pct_pkg::dec_t   dec_i,
  output logic                take_o,
  url_pct_out_if.source       rsp_o
);

  localparam int unsigned Depth  = url_pct_pkg::QueueDepth;
  localparam int unsigned CountW = url_pct_pkg::CountW;

  url_pct_pkg::result_t        slot_q [Depth];
  url_pct_pkg::result_t        slot_d [Depth];
  logic [CountW-1:0]           count_q, count_d;
  logic [CountW-1:0]           base;
  logic [CountW-1:0]           off;
  logic                        pop;

  assign pop            = rsp_o.valid && rsp_o.ready;
  assign rsp_o.valid    = (count_q != '0);
  assign rsp_o.out_byte = slot_q[0].data;
  assign rsp_o.out_last = slot_q[0].last;
  // room for a full three-result burst even if nothing leaves this cycle
  assign take_o         = (count_q <= CountW'(Depth - url_pct_pkg::MaxResults));

  always_comb begin
    base = count_q - CountW'(pop);
    off  = '0;
    for (int i = 0; i < Depth; i++) begin
      slot_d[i] = slot_q[i];
    end
    if (pop) begin
      for (int i = 0; i < Depth - 1; i++) begin
        slot_d[i] = slot_q[i + 1];
      end
    end
    for (int i = 0; i < Depth; i++) begin
      off = CountW'(i) - base;
      if (CountW'(i) >= base && off < CountW'(dec_i.num)) begin
        slot_d[i] = dec_i.res[off[url_pct_pkg::NumW-1:0]];
      end
    end
    count_d = base + CountW'(dec_i.num);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

endmodule

>>> sv/url_percent_decoder.sv
// url percent decoder top level
// Decodes a percent-encoded URL one byte per request: '+' turns into a space,
// '%' with two hex digits turns into one byte, and a '%' with a bad pair or
// too few bytes after it comes out raw. A byte is decoded in the cycle it is
// taken and its results land in a four-entry output queue, so a result can
// leave the cycle after its request. The queue hands out one result per
// cycle while the receiver is ready; requests are taken every cycle while
// it holds at most one result. A bad escape makes three results and holds
// the input off while they drain; bytes after a pending '%' make no result.
module url_percent_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  url_pct_in_if.sink      req_i,
  url_pct_out_if.source   rsp_o
);

  url_pct_pkg::dec_t dec;
  logic              take;

  url_pct_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .req_i  (req_i),
    .dec_o  (dec)
  );

  url_pct_out_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dec_i  (dec),
    .take_o (take),
    .rsp_o  (rsp_o)
  );

endmodule

>>> sv/url_pct_checker.sv
// port-level checks of the url percent decoder, bound to the top level
`include "url_percent_decoder_assert.svh"

module url_pct_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_last_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [url_pct_pkg::ByteW-1:0] out_byte_i,
  input logic                          out_last_i
);

  // a stalled result must hold
  `URL_PCT_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_byte_i) && $stable(out_last_i)), "result changed while stalled")

  // the end of a url always produces at least one result
  `URL_PCT_ASSERT(a_last_gives_result, clk_i, rst_ni, (in_valid_i && in_ready_i && in_last_i) |=> out_valid_i, "no result after final byte")

  // input only backs off while results are queued
  `URL_PCT_ASSERT(a_stall_has_cause, clk_i, rst_ni, !in_ready_i |-> out_valid_i, "input stalled with empty queue")

  // nothing is shown once reset has been seen at an edge
  `URL_PCT_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_i, "result valid during reset")

endmodule

bind url_percent_decoder url_pct_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_last_i   (req_i.in_last),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_byte_i  (rsp_o.out_byte),
  .out_last_i  (rsp_o.out_last)
);

>>> bench/tb.sv
// self-checking testbench for the url percent decoder
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import url_pct_pkg::*;

  localparam int  WatchdogLimit = 1000;
  localparam int  RandomItems   = 210;
  localparam int  TailCycles    = 40;
  localparam int  MaxReports    = 10;
  localparam logic BY_MODEL     = 1'b0;
  localparam logic TYPED        = 1'b1;

  // one request, with hand-typed results where they are obvious
  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    logic [1:0] n;
    logic [7:0] e0;
    logic [7:0] e1;
    logic [7:0] e2;
  } stim_t;

  localparam int DirRows = 27;
  stim_t dir_rows [DirRows] = '{
    '{8'h00,     1'b0, TYPED,    2'd1, 8'h00,     8'h00, 8'h00},
    '{8'hff,     1'b1, TYPED,    2'd1, 8'hff,     8'h00, 8'h00},
    '{ChPlus,    1'b0, TYPED,    2'd1, ChSpace,   8'h00, 8'h00},
    // percent then end of url
    '{ChPercent, 1'b1, TYPED,    2'd1, ChPercent, 8'h00, 8'h00},
    '{ChPercent, 1'b0, TYPED,    2'd0, 8'h00,     8'h00, 8'h00},
    '{"A",       1'b0, TYPED,    2'd0, 8'h00,     8'h00, 8'h00},
    '{"f",       1'b0, TYPED,    2'd1, 8'haf,     8'h00, 8'h00},
    '{ChPercent, 1'b0, TYPED,    2'd0, 8'h00,     8'h00, 8'h00},
    '{"0",       1'b0, TYPED,    2'd0, 8'h00,     8'h00, 8'h00},
    '{"9",       1'b1, TYPED,    2'd1, 8'h09,     8'h00, 8'h00},
    // bad pair comes out raw
    '{ChPercent, 1'b0, TYPED,    2'd0, 8'h00,     8'h00, 8'h00},
    '{"g",       1'b0, TYPED,    2'd0, 8'h00,     8'h00, 8'h00},
    '{"Z",       1'b0, TYPED,    2'd3, ChPercent, "g",   "Z"},
    // percent, one byte, end: the byte still gets the plus rule
    '{ChPercent, 1'b0, TYPED,    2'd0, 8'h00,     8'h00, 8'h00},
    '{ChPlus,    1'b1, TYPED,    2'd2, ChPercent, ChSpace, 8'h00},
    // plus inside a bad pair is not remapped
    '{ChPercent, 1'b0, TYPED,    2'd0, 8'h00,     8'h00, 8'h00},
    '{"F",       1'b0, TYPED,    2'd0, 8'h00,     8'h00, 8'h00},
    '{ChPlus,    1'b1, TYPED,    2'd3, ChPercent, "F",   ChPlus},
    // bytes just outside the hex ranges, then a pair of both letter cases
    '{ChPercent, 1'b0, BY_MODEL, 2'd0, 8'h00,     8'h00, 8'h00},
    '{"/",       1'b0, BY_MODEL, 2'd0, 8'h00,     8'h00, 8'h00},
    '{":",       1'b0, BY_MODEL, 2'd0, 8'h00,     8'h00, 8'h00},
    '{ChPercent, 1'b0, BY_MODEL, 2'd0, 8'h00,     8'h00, 8'h00},
    '{"@",       1'b0, BY_MODEL, 2'd0, 8'h00,     8'h00, 8'h00},
    '{"G",       1'b1, BY_MODEL, 2'd0, 8'h00,     8'h00, 8'h00},
    '{ChPercent, 1'b0, BY_MODEL, 2'd0, 8'h00,     8'h00, 8'h00},
    '{"F",       1'b0, BY_MODEL, 2'd0, 8'h00,     8'h00, 8'h00},
    '{"f",       1'b1, BY_MODEL, 2'd0, 8'h00,     8'h00, 8'h00}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  url_pct_in_if  req_if ();
  url_pct_out_if rsp_if ();

  url_percent_decoder u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk = ~clk;

  mode_e      esc_state = MODE_IDLE;
  logic [7:0] held_byte = '0;
  stim_t      url_stream [$];
  result_t    pending_bytes [$];
  int         errors      = 0;
  int         idle_cycles = 0;
  int         src_quiet   = 0;
  int         sink_quiet  = 0;

  function automatic logic is_hex(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    return (c >= "0" && c <= "9") || (lc >= "a" && lc <= "f");
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = (c <= "9") ? c - 8'h30 : (c | 8'h20) - 8'h57;
    return v[3:0];
  endfunction

  function automatic logic [7:0] unplus(input logic [7:0] c);
    return (c == ChPlus) ? ChSpace : c;
  endfunction

  // decodes one request against the predictor state, returns the result count
  function automatic int decode_byte(input logic [7:0] c, input logic fin,
                                     output result_t [2:0] r);
    int n;
    n = 0;
    r = '0;
    case (esc_state)
      MODE_PCT: begin
        if (fin) begin
          r[0] = '{ChPercent, 1'b0};
          r[1] = '{unplus(c), 1'b1};
          n = 2;
        end else begin
          held_byte = c;
          esc_state = MODE_HELD;
        end
      end
      MODE_HELD: begin
        if (is_hex(held_byte) && is_hex(c)) begin
          r[0] = '{{hex_nibble(held_byte), hex_nibble(c)}, fin};
          n = 1;
        end else begin
          r[0] = '{ChPercent, 1'b0};
          r[1] = '{held_byte, 1'b0};
          r[2] = '{c, fin};
          n = 3;
        end
        esc_state = MODE_IDLE;
        held_byte = '0;
      end
      default: begin
        if (c == ChPercent && !fin) begin
          esc_state = MODE_PCT;
        end else begin
          r[0] = '{unplus(c), fin};
          n = 1;
        end
      end
    endcase
    if (fin) begin
      esc_state = MODE_IDLE;
      held_byte = '0;
    end
    return n;
  endfunction

  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= MaxReports) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void push_byte(input logic [7:0] c, input logic fin);
    url_stream.push_back('{c, fin, BY_MODEL, 2'd0, 8'h00, 8'h00, 8'h00});
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'(v) + 8'h30;
    if (v < 16) return 8'(v) + 8'h57;
    return 8'(v) + 8'h31;
  endfunction

  // a url of random tokens, bad escapes among them, sometimes cut short after a percent
  function automatic void build_url();
    int         ntok;
    int         kind;
    logic [7:0] c;
    ntok = $urandom_range(1, 8);
    for (int t = 0; t < ntok; t++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        c = 8'($urandom_range(0, 255));
        push_byte((c == ChPercent) ? ChPlus : c, 1'b0);
      end else if (kind == 3) begin
        push_byte(ChPlus, 1'b0);
      end else if (kind <= 6) begin
        push_byte(ChPercent, 1'b0);
        push_byte(hex_char(), 1'b0);
        push_byte(hex_char(), 1'b0);
      end else if (kind <= 8) begin
        push_byte(ChPercent, 1'b0);
        push_byte($urandom_range(0, 1) ? hex_char() : 8'($urandom_range(0, 255)), 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        push_byte(ChPercent, 1'b0);
        if ($urandom_range(0, 1)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        break;
      end
    end
    url_stream[url_stream.size()-1].fin = 1'b1;
  endfunction

  initial begin
    req_if.valid   = 1'b0;
    req_if.in_byte = '0;
    req_if.in_last = 1'b0;
    rsp_if.ready   = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: no request or result moved for %0d cycles", idle_cycles);
        $display("FAIL url_percent_decoder");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int      gap;
    result_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(sink_quiet);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      if (pending_bytes.size() == 0) begin
        note_error($sformatf("unexpected result byte %h last %b",
                             rsp_if.out_byte, rsp_if.out_last));
      end else begin
        want = pending_bytes.pop_front();
        if (want.data !== rsp_if.out_byte || want.last !== rsp_if.out_last) begin
          note_error($sformatf("result byte %h last %b, expected byte %h last %b",
                               rsp_if.out_byte, rsp_if.out_last, want.data, want.last));
        end
      end
    end
  end

  initial begin : request_source
    int             gap;
    int             n;
    stim_t          s;
    result_t [2:0]  r;
    logic    [7:0]  typed_b [3];
    foreach (dir_rows[i]) url_stream.push_back(dir_rows[i]);
    while (url_stream.size() < RandomItems) begin
      // noise: a stray byte that may break off a url or start a bad escape
      if ($urandom_range(0, 5) == 0) begin
        push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
      end else begin
        build_url();
      end
    end

    while (!rst_n) @(posedge clk);
    while (url_stream.size() != 0) begin
      s = url_stream.pop_front();
      gap = draw_gap(src_quiet);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= s.b;
      req_if.in_last <= s.fin;
      do @(posedge clk); while (!req_if.ready);
      n = decode_byte(s.b, s.fin, r);
      if (s.typed) begin
        typed_b = '{s.e0, s.e1, s.e2};
        for (int k = 0; k < s.n; k++) begin
          pending_bytes.push_back('{typed_b[k], s.fin && (k == s.n - 1)});
        end
      end else begin
        for (int k = 0; k < n; k++) pending_bytes.push_back(r[k]);
      end
    end
    req_if.valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("PASS url_percent_decoder");
    end else begin
      $display("FAIL url_percent_decoder");
    end
    $finish;
  end

endmodule
